### rtl/lsfs_pkg.sv
// ----------------------------------------------------------------------------
// Letter shift frequency scorer package
// Shared types, constants and the English letter frequency table.
// ----------------------------------------------------------------------------
package lsfs_pkg;

    localparam int NUM_BINS      = 26;
    localparam int IDX_W         = 5;
    localparam int COUNT_W       = 16;
    localparam int MAX_LETTERS   = 65535;
    localparam int PERCENT_SCALE = 100000;
    localparam int EN_W          = 14;
    // A single term is below 65535 * 100000, which needs 33 bits.
    localparam int HAVE_W        = 33;
    // The whole sum is bounded by N * (100000 + sum of the table), below 2^34.
    localparam int SCORE_W       = 34;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);

    typedef struct packed {
        logic [4:0] letter;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [4:0]  best_shift;
        logic [33:0] best_score;
        logic        overflow;
    } t_out;

    typedef struct packed {
        logic             count_en;
        logic             clear;
        logic             issue;
        logic [IDX_W-1:0] plain;
        logic [IDX_W-1:0] cipher;
        logic [IDX_W-1:0] shift;
    } t_cmd;

    typedef struct packed {
        logic score_done;
    } t_status;

    // English letter frequency in thousandths of a percent.
    function automatic logic [EN_W-1:0] en_freq(input logic [IDX_W-1:0] idx);
        logic [EN_W-1:0] f;
        case (idx)
            5'd0:    f = 14'd8200;
            5'd1:    f = 14'd1500;
            5'd2:    f = 14'd2800;
            5'd3:    f = 14'd4300;
            5'd4:    f = 14'd13000;
            5'd5:    f = 14'd2200;
            5'd6:    f = 14'd2000;
            5'd7:    f = 14'd6100;
            5'd8:    f = 14'd7000;
            5'd9:    f = 14'd150;
            5'd10:   f = 14'd770;
            5'd11:   f = 14'd4000;
            5'd12:   f = 14'd2400;
            5'd13:   f = 14'd6700;
            5'd14:   f = 14'd7500;
            5'd15:   f = 14'd1900;
            5'd16:   f = 14'd95;
            5'd17:   f = 14'd6000;
            5'd18:   f = 14'd6300;
            5'd19:   f = 14'd9100;
            5'd20:   f = 14'd2800;
            5'd21:   f = 14'd980;
            5'd22:   f = 14'd2400;
            5'd23:   f = 14'd150;
            5'd24:   f = 14'd2000;
            5'd25:   f = 14'd74;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

### rtl/letter_shift_frequency_scorer_top.sv
// ----------------------------------------------------------------------------
// Letter shift frequency scorer, top level
// Caesar shift search over one cipher column by English letter frequency.
// ----------------------------------------------------------------------------
// A column of letters (codes 0 to 25) is fed one transaction per cycle while
// busy is low; each letter is counted in the cycle it is taken, so letters may
// follow back to back. The transaction flagged last is counted and then starts
// the scoring sweep: busy stays high while the 676 terms of the 26 shifts
// times 26 letters pass one at a time through the single shared multiply,
// difference and accumulate unit, and while the scoring pipeline drains.
// The result is presented on o_result with o_done high for exactly one cycle,
// the last busy cycle, and the receiver cannot stall it, so it must be captured
// then. Codes 26 to 31 are not counted, letters beyond 65535 in one column are
// refused and flagged through overflow, and the histogram is cleared after
// each result so that the next column starts from empty.
// ----------------------------------------------------------------------------
module letter_shift_frequency_scorer_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  lsfs_pkg::t_in  i_item,
    output logic           o_done,
    output lsfs_pkg::t_out o_result
);
    import lsfs_pkg::*;

    // Commands from the controller to the datapath and status back.
    t_cmd    w_cmd;
    t_status w_status;

    // The controller owns the sequencing: it counts plain letter, cipher letter
    // and shift during the sweep and decides when a result is shown.
    lsfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_item.last),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // The datapath holds the histogram and the three-stage scoring pipeline;
    // it reports when the final shift has been compared.
    lsfs_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (o_result)
    );

endmodule

### rtl/lsfs_ctrl.sv
// ----------------------------------------------------------------------------
// Letter shift frequency scorer controller
// Sequences letter counting, the shift by letter scoring sweep and the result.
// ----------------------------------------------------------------------------
module lsfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_last,
    input  lsfs_pkg::t_status i_status,
    output lsfs_pkg::t_cmd    o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import lsfs_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCORE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]       r_state,  n_state;
    logic [IDX_W-1:0] r_plain,  n_plain;
    logic [IDX_W-1:0] r_cipher, n_cipher;
    logic [IDX_W-1:0] r_shift,  n_shift;

    always_comb begin
        n_state  = r_state;
        n_plain  = r_plain;
        n_cipher = r_cipher;
        n_shift  = r_shift;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_last) begin
                    n_state  = S_SCORE;
                    n_plain  = '0;
                    n_cipher = '0;
                    n_shift  = '0;
                end
            end
            S_SCORE: begin
                if (r_plain == LAST_IDX) begin
                    // The cipher index at the last plain letter is already the
                    // starting index of the next shift, so it holds.
                    n_plain = '0;
                    if (r_shift == LAST_IDX) begin
                        n_state = S_DRAIN;
                        n_shift = '0;
                    end else begin
                        n_shift = r_shift + 1'b1;
                    end
                end else begin
                    n_plain  = r_plain + 1'b1;
                    n_cipher = (r_cipher == LAST_IDX) ? '0 : r_cipher + 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_status.score_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_plain  <= '0;
            r_cipher <= '0;
            r_shift  <= '0;
        end else begin
            r_state  <= n_state;
            r_plain  <= n_plain;
            r_cipher <= n_cipher;
            r_shift  <= n_shift;
        end
    end

    always_comb begin
        o_cmd.count_en = (r_state == S_IDLE) && i_start;
        o_cmd.clear    = (r_state == S_EMIT);
        o_cmd.issue    = (r_state == S_SCORE);
        o_cmd.plain    = r_plain;
        o_cmd.cipher   = r_cipher;
        o_cmd.shift    = r_shift;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_EMIT);

endmodule

### rtl/lsfs_dpath.sv
// ----------------------------------------------------------------------------
// Letter shift frequency scorer datapath
// Histogram, letter total, and the pipelined scoring and best-shift unit.
// ----------------------------------------------------------------------------
module lsfs_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsfs_pkg::t_in     i_item,
    input  lsfs_pkg::t_cmd    i_cmd,
    output lsfs_pkg::t_status o_status,
    output lsfs_pkg::t_out    o_result
);
    import lsfs_pkg::*;

    logic [COUNT_W-1:0] r_count [NUM_BINS];
    logic [COUNT_W-1:0] r_total, n_total;
    logic               r_sat,   n_sat;
    logic               w_inc;

    // Scoring stage A: the two products of one term.
    logic               r_a_valid;
    logic               r_a_first;
    logic               r_a_last;
    logic [IDX_W-1:0]   r_a_shift;
    logic [HAVE_W-1:0]  r_have, n_have;
    logic [HAVE_W-1:0]  r_want, n_want;

    // Scoring stage B: accumulation over the plain letters of one shift.
    logic               r_b_last;
    logic [IDX_W-1:0]   r_b_shift;
    logic [HAVE_W-1:0]  w_diff;
    logic [SCORE_W-1:0] r_acc, n_acc;

    // Scoring stage C: best shift so far.
    logic               r_c_final;
    logic [IDX_W-1:0]   r_best_shift;
    logic [SCORE_W-1:0] r_best_score;

    assign w_inc = i_cmd.count_en && (i_item.letter < IDX_W'(NUM_BINS))
                   && (r_total < COUNT_W'(MAX_LETTERS));

    always_comb begin
        n_total = r_total;
        n_sat   = r_sat;
        if (i_cmd.clear) begin
            n_total = '0;
            n_sat   = 1'b0;
        end else if (i_cmd.count_en && (i_item.letter < IDX_W'(NUM_BINS))) begin
            if (r_total < COUNT_W'(MAX_LETTERS)) begin
                n_total = r_total + 1'b1;
            end else begin
                n_sat = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BINS; b++) begin
                r_count[b] <= '0;
            end
            r_total <= '0;
            r_sat   <= 1'b0;
        end else begin
            for (int b = 0; b < NUM_BINS; b++) begin
                if (i_cmd.clear) begin
                    r_count[b] <= '0;
                end else if (w_inc && (i_item.letter == IDX_W'(b))) begin
                    r_count[b] <= r_count[b] + 1'b1;
                end
            end
            r_total <= n_total;
            r_sat   <= n_sat;
        end
    end

    assign n_have = HAVE_W'(r_count[i_cmd.cipher]) * HAVE_W'(PERCENT_SCALE);
    assign n_want = HAVE_W'(en_freq(i_cmd.plain)) * HAVE_W'(r_total);

    assign w_diff = (r_have >= r_want) ? (r_have - r_want) : (r_want - r_have);
    assign n_acc  = (r_a_first ? '0 : r_acc) + SCORE_W'(w_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_last  <= 1'b0;
            r_c_final <= 1'b0;
        end else begin
            r_a_valid <= i_cmd.issue;
            r_b_last  <= r_a_valid && r_a_last;
            r_c_final <= r_b_last && (r_b_shift == LAST_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_have    <= n_have;
        r_want    <= n_want;
        r_a_first <= (i_cmd.plain == '0);
        r_a_last  <= (i_cmd.plain == LAST_IDX);
        r_a_shift <= i_cmd.shift;
        r_b_shift <= r_a_shift;
        if (r_a_valid) begin
            r_acc <= n_acc;
        end
        if (r_b_last && ((r_b_shift == '0) || (r_acc < r_best_score))) begin
            r_best_shift <= r_b_shift;
            r_best_score <= r_acc;
        end
    end

    assign o_status.score_done = r_c_final;

    always_comb begin
        o_result.best_shift = r_best_shift;
        o_result.best_score = r_best_score;
        o_result.overflow   = r_sat;
    end

endmodule

### rtl/lsfs_checker.sv
// ----------------------------------------------------------------------------
// Letter shift frequency scorer checker
// Port-level assertions on the handshake and result timing of the top level.
// ----------------------------------------------------------------------------
module lsfs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input lsfs_pkg::t_in  i_item,
    input logic           o_done,
    input lsfs_pkg::t_out o_result
);
    import lsfs_pkg::*;

    // A result is only ever shown while a column is being scored.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while not busy");

    // After the result the block is ready for the next column at once.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("block not idle after result");

    // A letter that is not flagged last never stalls the input side.
    a_mid_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_item.last) |=> !busy)
        else $error("busy after a letter that is not last");

    // The last letter of a column starts scoring.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.last) |=> (busy && !o_done))
        else $error("scoring not started by the last letter");

    // The reported shift is a letter distance.
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.best_shift <= LAST_IDX))
        else $error("best shift out of range");

endmodule

bind letter_shift_frequency_scorer_top lsfs_checker u_lsfs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_done   (o_done),
    .o_result (o_result)
);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Letter shift frequency scorer testbench
// Feeds cipher columns through the start/busy command port and checks every
// scored column against an in-bench predictor of the histogram and the search.
// ----------------------------------------------------------------------------
// The bench keeps its own letter histogram, letter total and saturation flag.
// It updates them on every transaction that the block takes. A transaction
// flagged last makes the predictor try all 26 shifts and queue the winning
// shift, its score and the overflow flag. Each o_done strobe is compared field
// by field with the oldest queued column score.
//
// Stimulus runs in named tests, in this order:
//   - a short directed set: an empty column, single letters at both ends of
//     the alphabet, ignored codes 26 to 31 (one of them carrying last), and a
//     short English phrase under a known shift;
//   - random columns, mostly English-like text under a random shift, the rest
//     uniform letters and noisy columns with ignored codes mixed in.
// The sender inserts random gaps between transactions, and it holds start
// high through the busy scoring sweep so that refused starts are exercised.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsfs_pkg::*;

    // The scoring sweep keeps busy high while it runs. Without stalls
    // on the receive side, a transaction or a result should never be further
    // apart than one sweep plus the longest sender gap, so the watchdog allows
    // several times as much.
    localparam int SWEEP_CYCLES    = 680;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_LETTERS  = 1450;
    localparam int MAX_REPORTS     = 10;
    localparam logic [63:0] SCORE_CAP = 64'h3_FFFF_FFFF;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    logic  busy;
    t_in   i_item  = '0;
    logic  o_done;
    t_out  o_result;

    // English letter frequency in thousandths of a percent, a to z.
    int unsigned en_milli_pct [NUM_BINS] = '{
        8200, 1500, 2800, 4300, 13000, 2200, 2000, 6100, 7000, 150,
        770, 4000, 2400, 6700, 7500, 1900, 95, 6000, 6300, 9100,
        2800, 980, 2400, 150, 2000, 74
    };

    // Predicted column state, kept at the block's own widths.
    logic [15:0] letter_hist [NUM_BINS];
    logic [15:0] letter_total;
    logic        col_saturated;

    t_out pending_scores [$];

    int accepted_items = 0;
    int idle_cycles    = 0;
    int mismatches     = 0;

    letter_shift_frequency_scorer_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void clear_column();
        foreach (letter_hist[b]) begin
            letter_hist[b] = '0;
        end
        letter_total  = '0;
        col_saturated = 1'b0;
    endfunction

    // Tries every shift over the current histogram. The first shift with the
    // lowest sum wins; the reported score is clamped to 34 bits while the
    // comparison uses the full sums.
    function automatic t_out score_column();
        t_out        res;
        logic [63:0] sum;
        logic [63:0] best_sum;
        logic [63:0] have;
        logic [63:0] want;
        int          cipher;
        res      = '0;
        best_sum = '0;
        for (int s = 0; s < NUM_BINS; s++) begin
            sum = '0;
            for (int p = 0; p < NUM_BINS; p++) begin
                cipher = (p + NUM_BINS - s) % NUM_BINS;
                have   = 64'(letter_hist[cipher]) * 64'd100000;
                want   = 64'(en_milli_pct[p]) * 64'(letter_total);
                sum   += (have >= want) ? (have - want) : (want - have);
            end
            if (s == 0 || sum < best_sum) begin
                best_sum       = sum;
                res.best_shift = 5'(s);
            end
        end
        res.best_score = (best_sum > SCORE_CAP) ? SCORE_CAP[33:0] : best_sum[33:0];
        res.overflow   = col_saturated;
        return res;
    endfunction

    // Applies one accepted transaction to the predicted column state.
    function automatic void count_letter(input t_in item);
        if (item.letter < NUM_BINS) begin
            if (letter_total >= 16'(MAX_LETTERS)) begin
                col_saturated = 1'b1;
            end else begin
                letter_hist[item.letter] = letter_hist[item.letter] + 16'd1;
                letter_total             = letter_total + 16'd1;
            end
        end
        if (item.last) begin
            pending_scores.push_back(score_column());
            clear_column();
        end
    endfunction

    function automatic void check_result(input t_out got);
        t_out want;
        if (pending_scores.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("[%0t] unexpected result: shift %0d score %0d overflow %0b",
                         $realtime, got.best_shift, got.best_score, got.overflow);
            end
            return;
        end
        want = pending_scores.pop_front();
        if (got.best_shift !== want.best_shift || got.best_score !== want.best_score ||
            got.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("[%0t] result mismatch: expected shift %0d score %0d overflow %0b",
                         $realtime, want.best_shift, want.best_score, want.overflow);
                $display("[%0t]                  actual   shift %0d score %0d overflow %0b",
                         $realtime, got.best_shift, got.best_score, got.overflow);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor and watchdog
    // ------------------------------------------------------------------------
    // Everything is sampled at the rising edge, where inputs have been stable
    // since the falling edge. The result is checked before a new transaction
    // is counted, although the two cannot meet since o_done falls in a busy
    // cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (o_done) begin
                check_result(o_result);
                idle_cycles = 0;
            end
            if (start && !busy) begin
                count_letter(i_item);
                accepted_items++;
                idle_cycles = 0;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog expired after %0d quiet cycles",
                         $realtime, idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Called at a falling edge. Offers one transaction and returns at the
    // falling edge after the rising edge that took it, with start still high.
    task automatic send_letter(input logic [4:0] code, input logic is_last);
        int seen;
        seen   = accepted_items;
        start  <= 1'b1;
        i_item <= '{letter: code, last: is_last};
        do begin
            @(negedge i_clk);
        end while (accepted_items == seen);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Mostly back to back, often a short gap, now and then a long one.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // Draws a plain letter with English weights.
    function automatic logic [4:0] english_letter();
        int unsigned weight_sum;
        int unsigned pick;
        weight_sum = 0;
        foreach (en_milli_pct[p]) begin
            weight_sum += en_milli_pct[p];
        end
        pick = $urandom_range(0, weight_sum - 1);
        foreach (en_milli_pct[p]) begin
            if (pick < en_milli_pct[p]) begin
                return 5'(p);
            end
            pick -= en_milli_pct[p];
        end
        return 5'(NUM_BINS - 1);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_directed();
        string phrase;
        int    code;
        phrase = "thequickbrownfox";
        // An empty column: only an ignored code, carrying last.
        send_letter(5'd31, 1'b1);
        // Single letters at both ends of the alphabet.
        send_letter(5'd0, 1'b1);
        pause(2);
        send_letter(5'd25, 1'b1);
        // Ignored codes mixed with letters; the last flag sits on an ignored code.
        send_letter(5'd26, 1'b0);
        send_letter(5'd4, 1'b0);
        send_letter(5'd30, 1'b0);
        send_letter(5'd19, 1'b0);
        send_letter(5'd27, 1'b1);
        pause(1);
        // A short English phrase enciphered with a shift of three.
        for (int k = 0; k < phrase.len(); k++) begin
            code = (int'(phrase[k]) - int'("a") + NUM_BINS - 3) % NUM_BINS;
            send_letter(5'(code), k == phrase.len() - 1);
            pause(random_gap());
        end
    endtask

    task automatic test_random_columns();
        int          letters_sent;
        int          length;
        int          shift;
        int          mode;
        bit          no_gaps;
        bit          is_last;
        logic [4:0]  code;
        letters_sent = 0;
        while (letters_sent < RANDOM_LETTERS) begin
            length  = ($urandom_range(0, 19) == 0) ? $urandom_range(80, 250)
                                                   : $urandom_range(1, 40);
            shift   = $urandom_range(0, NUM_BINS - 1);
            mode    = $urandom_range(0, 9);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < length; k++) begin
                is_last = (k == length - 1);
                if (mode < 7) begin
                    // English-like text under this column's shift.
                    code = 5'((int'(english_letter()) + NUM_BINS - shift) % NUM_BINS);
                end else if (mode < 9) begin
                    code = 5'($urandom_range(0, NUM_BINS - 1));
                end else if ($urandom_range(0, 3) == 0) begin
                    // Noise: an ignored code, sometimes on the final transaction.
                    code = 5'($urandom_range(NUM_BINS, 31));
                end else begin
                    code = 5'($urandom_range(0, NUM_BINS - 1));
                end
                send_letter(code, is_last);
                if (code < NUM_BINS) begin
                    letters_sent++;
                end
                if (!no_gaps) begin
                    pause(random_gap());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_column();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_columns();

        start <= 1'b0;
        // Wait for the outstanding column scores, then for one more sweep in
        // case the block produces anything it should not.
        while (pending_scores.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SWEEP_CYCLES + 20) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
